// ===== sv/ssw_pkg.sv =====
`default_nettype none

package ssw_pkg;

    localparam logic [4:0] MAX_SERVOS         = 5'd31;
    localparam logic [7:0] DATA_LEN_PER_SERVO = 8'd7;
    localparam logic [7:0] LEN_OVERHEAD       = 8'd4;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [2:0] REG_HEADER_FIRST     = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND    = 3'd1;
    localparam logic [2:0] REG_BROADCAST_ID     = 3'd2;
    localparam logic [2:0] REG_SYNC_INSTRUCTION = 3'd3;
    localparam logic [2:0] REG_START_REGISTER   = 3'd4;
    localparam logic [2:0] REG_SERVO_COUNT      = 3'd5;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] broadcast_id;
        logic [7:0] sync_instruction;
        logic [7:0] start_register;
        logic [4:0] servo_count;
    } ssw_cfg_t;

    // One classified entry as it waits for the byte sequencer.
    typedef struct packed {
        logic        has_header;
        logic        has_checksum;
        logic [7:0]  unit_id;
        logic [7:0]  goal_acceleration;
        logic [15:0] position_word;
        logic [15:0] goal_speed;
    } ssw_entry_t;

    // A count of zero means one entry per packet.
    function automatic logic [4:0] eff_count(input logic [4:0] count);
        logic [4:0] c;
        c = count;
        if (c == 5'd0)
        begin
            c = 5'd1;
        end
        if (c > MAX_SERVOS)
        begin
            c = MAX_SERVOS;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssw_regs.sv =====
`default_nettype none

module ssw_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output ssw_pkg::ssw_cfg_t     cfg
);

    ssw_pkg::ssw_cfg_t cfg_reg;
    logic [2:0]        reg_index;
    logic              write_en;

    assign reg_index = paddr[4:2];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first     <= 8'hFF;
            cfg_reg.header_second    <= 8'hFF;
            cfg_reg.broadcast_id     <= 8'd254;
            cfg_reg.sync_instruction <= 8'd131;
            cfg_reg.start_register   <= 8'd41;
            cfg_reg.servo_count      <= 5'd2;
        end
        else if (write_en)
        begin
            case (reg_index)
                ssw_pkg::REG_HEADER_FIRST:     cfg_reg.header_first     <= pwdata[7:0];
                ssw_pkg::REG_HEADER_SECOND:    cfg_reg.header_second    <= pwdata[7:0];
                ssw_pkg::REG_BROADCAST_ID:     cfg_reg.broadcast_id     <= pwdata[7:0];
                ssw_pkg::REG_SYNC_INSTRUCTION: cfg_reg.sync_instruction <= pwdata[7:0];
                ssw_pkg::REG_START_REGISTER:   cfg_reg.start_register   <= pwdata[7:0];
                ssw_pkg::REG_SERVO_COUNT:      cfg_reg.servo_count      <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            ssw_pkg::REG_HEADER_FIRST:     prdata = {24'd0, cfg_reg.header_first};
            ssw_pkg::REG_HEADER_SECOND:    prdata = {24'd0, cfg_reg.header_second};
            ssw_pkg::REG_BROADCAST_ID:     prdata = {24'd0, cfg_reg.broadcast_id};
            ssw_pkg::REG_SYNC_INSTRUCTION: prdata = {24'd0, cfg_reg.sync_instruction};
            ssw_pkg::REG_START_REGISTER:   prdata = {24'd0, cfg_reg.start_register};
            ssw_pkg::REG_SERVO_COUNT:      prdata = {27'd0, cfg_reg.servo_count};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ssw_front.sv =====
`default_nettype none

module ssw_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,
    input  wire logic [4:0]        servo_count,
    input  wire logic              q_full,
    output logic                   q_wr_en,
    output ssw_pkg::ssw_entry_t    q_wr_data
);

    logic [4:0]  entry_index_reg;
    logic [4:0]  entry_index_next;
    logic [4:0]  count;
    logic        last_entry;
    logic [15:0] raw_pos;
    logic [15:0] neg_pos;
    logic [14:0] magnitude;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_wr_en  = accept;

    assign count      = ssw_pkg::eff_count(servo_count);
    assign last_entry = ({1'b0, entry_index_reg} + 6'd1) >= {1'b0, count};

    // Sign-magnitude: the most negative value saturates to full magnitude.
    assign raw_pos = s_tdata[23:8];
    assign neg_pos = 16'(~raw_pos + 16'd1);
    assign magnitude = (raw_pos == 16'h8000) ? 15'h7FFF : neg_pos[14:0];

    always_comb
    begin
        q_wr_data.has_header        = (entry_index_reg == 5'd0);
        q_wr_data.has_checksum      = last_entry;
        q_wr_data.unit_id           = s_tdata[7:0];
        q_wr_data.goal_acceleration = s_tdata[47:40];
        q_wr_data.goal_speed        = s_tdata[39:24];
        q_wr_data.position_word     = raw_pos[15] ? {1'b1, magnitude} : raw_pos;
    end

    always_comb
    begin
        entry_index_next = entry_index_reg;
        if (accept)
        begin
            entry_index_next = last_entry ? 5'd0 : 5'(entry_index_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_index_reg <= 5'd0;
        end
        else
        begin
            entry_index_reg <= entry_index_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssw_queue.sv =====
`default_nettype none

module ssw_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire ssw_pkg::ssw_entry_t wr_data,
    output logic                     full,
    output logic [1:0]               level,
    output logic                     rd_valid,
    output ssw_pkg::ssw_entry_t      rd_data,
    input  wire logic                pop
);

    ssw_pkg::ssw_entry_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          level_reg;
    logic [1:0]          level_next;

    assign full     = (level_reg == 2'd2);
    assign level    = level_reg;
    assign rd_valid = (level_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (wr_en && !pop)
        begin
            level_next = 2'(level_reg + 2'd1);
        end
        else if (pop && !wr_en)
        begin
            level_next = 2'(level_reg - 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssw_back.sv =====
`default_nettype none

module ssw_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ssw_pkg::ssw_cfg_t   cfg,
    input  wire logic                q_valid,
    input  wire ssw_pkg::ssw_entry_t q_data,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    output logic [0:0]               m_tuser
);

    localparam logic [3:0] STEP_HDR1    = 4'd0;
    localparam logic [3:0] STEP_HDR2    = 4'd1;
    localparam logic [3:0] STEP_BCAST   = 4'd2;
    localparam logic [3:0] STEP_LEN     = 4'd3;
    localparam logic [3:0] STEP_INSTR   = 4'd4;
    localparam logic [3:0] STEP_START   = 4'd5;
    localparam logic [3:0] STEP_DLEN    = 4'd6;
    localparam logic [3:0] STEP_ID      = 4'd7;
    localparam logic [3:0] STEP_ACC     = 4'd8;
    localparam logic [3:0] STEP_POS_LO  = 4'd9;
    localparam logic [3:0] STEP_POS_HI  = 4'd10;
    localparam logic [3:0] STEP_TIME_LO = 4'd11;
    localparam logic [3:0] STEP_TIME_HI = 4'd12;
    localparam logic [3:0] STEP_SPD_LO  = 4'd13;
    localparam logic [3:0] STEP_SPD_HI  = 4'd14;
    localparam logic [3:0] STEP_CHK     = 4'd15;

    logic       started_reg;
    logic [3:0] step_reg;
    logic [7:0] sum_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic [3:0] cur_step;
    logic [7:0] cur_byte;
    logic [7:0] len_byte;
    logic       advance;
    logic       last_byte;

    assign len_byte = 8'({ssw_pkg::eff_count(cfg.servo_count), 3'b000})
                      + ssw_pkg::LEN_OVERHEAD;

    // The first step of a new entry is decided straight from the queue head.
    assign cur_step  = started_reg ? step_reg
                                   : (q_data.has_header ? STEP_HDR1 : STEP_ID);
    assign advance   = q_valid && (!m_tvalid_reg || m_tready);
    assign last_byte = (cur_step == STEP_CHK)
                    || ((cur_step == STEP_SPD_HI) && !q_data.has_checksum);
    assign q_pop     = advance && last_byte;

    always_comb
    begin
        case (cur_step)
            STEP_HDR1:    cur_byte = cfg.header_first;
            STEP_HDR2:    cur_byte = cfg.header_second;
            STEP_BCAST:   cur_byte = cfg.broadcast_id;
            STEP_LEN:     cur_byte = len_byte;
            STEP_INSTR:   cur_byte = cfg.sync_instruction;
            STEP_START:   cur_byte = cfg.start_register;
            STEP_DLEN:    cur_byte = ssw_pkg::DATA_LEN_PER_SERVO;
            STEP_ID:      cur_byte = q_data.unit_id;
            STEP_ACC:     cur_byte = q_data.goal_acceleration;
            STEP_POS_LO:  cur_byte = q_data.position_word[7:0];
            STEP_POS_HI:  cur_byte = q_data.position_word[15:8];
            STEP_TIME_LO: cur_byte = 8'd0;
            STEP_TIME_HI: cur_byte = 8'd0;
            STEP_SPD_LO:  cur_byte = q_data.goal_speed[7:0];
            STEP_SPD_HI:  cur_byte = q_data.goal_speed[15:8];
            STEP_CHK:     cur_byte = ~sum_reg;
            default:      cur_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= last_byte;
            m_tuser_reg <= (cur_step == STEP_CHK);
            if (cur_step == STEP_HDR1)
            begin
                sum_reg <= 8'd0;
            end
            else if (cur_step inside {[STEP_BCAST:STEP_SPD_HI]})
            begin
                sum_reg <= 8'(sum_reg + cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            step_reg     <= STEP_HDR1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                m_tvalid_reg <= 1'b1;
                started_reg  <= !last_byte;
                step_reg     <= 4'(cur_step + 4'd1);
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

// ===== sv/servo_sync_write_framer.sv =====
`default_nettype none

// Channel   Direction  Payload
// s_*       in         tdata: unit_id, goal_position, goal_speed, goal_acceleration
// m_*       out        tdata: frame_byte; tlast: run_last; tuser: packet_end
// APB       in/out     six configuration registers at byte addresses 0 to 20
//
// One packet byte leaves per cycle from the single output register while m_tready
// is high; an entry is 8 bytes, 15 with the header, 9 with the checksum and 16 with both.
// A two-entry queue lets the input side take new entries while bytes drain.
// Reset clears the entry index, the queue and the output valid; configuration
// returns to its default values.  A low m_tready holds the current byte.

module servo_sync_write_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] unit_id, [23:8] goal_position, [39:24] goal_speed,
    // [47:40] goal_acceleration
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] frame_byte
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // [0] packet_end
    output logic [0:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ssw_pkg::ssw_cfg_t   cfg;
    ssw_pkg::ssw_entry_t q_wr_data;
    ssw_pkg::ssw_entry_t q_rd_data;
    logic                q_wr_en;
    logic                q_full;
    logic [1:0]          q_level;
    logic                q_valid;
    logic                q_pop;

    ssw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .servo_count (cfg.servo_count),
        .q_full      (q_full),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    ssw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .level    (q_level),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data),
        .pop      (q_pop)
    );

    ssw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("checksum byte without end of run");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (q_level == 2'd2))
        else $error("input stalled with room in the queue");

    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr_en && !q_pop) |=> (q_level == 2'($past(q_level) + 2'd1)))
        else $error("queue level lost a write");
`endif

endmodule

`default_nettype wire
